/* sv/flow_priority_queue_defines.svh */
// assertion macros shared by the flow priority queue modules
// needs clk_i and rst_ni in the scope of each use
`ifndef FLOW_PRIORITY_QUEUE_DEFINES_SVH
`define FLOW_PRIORITY_QUEUE_DEFINES_SVH

// checked only while out of reset
`define FPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/fpq_pkg.sv */
// types, codes and the ordering rule of the flow priority queue
// no dependencies
`timescale 1ns / 1ps

package fpq_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DROP  = 2'd2
  } status_e;

  // one flow record, flow_id in the lowest bits
  typedef struct packed {
    logic [7:0]  priority_req;
    logic [15:0] transmit_time;
    logic [15:0] arrival_time;
    logic [7:0]  flow_id;
  } rec_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic valid;
    logic ins;
    rec_t rec;
  } link_t;

  // one result beat
  typedef struct packed {
    status_e status;
    logic    full;
    logic    empty;
    rec_t    rec;
  } res_t;

  // true when a must leave strictly before b
  function automatic logic ranks_before(rec_t a, rec_t b);
    return {a.priority_req, a.arrival_time, a.transmit_time}
         < {b.priority_req, b.arrival_time, b.transmit_time};
  endfunction

endpackage

/* sv/fpq_cell.sv */
// one slot of the sorted shift chain
// depends on fpq_pkg
`timescale 1ns / 1ps

module fpq_cell import fpq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  logic  pop_i,
  input  rec_t  new_rec_i,
  input  link_t left_i,
  input  link_t right_i,
  output link_t link_o
);

  logic valid_q, valid_d;
  rec_t rec_q, rec_d;
  logic ins;

  // the new record belongs at or before this slot
  assign ins = !valid_q || ranks_before(new_rec_i, rec_q);

  // shift right on insert, shift left on pop
  always_comb begin
    valid_d = valid_q;
    rec_d   = rec_q;
    if (push_i && ins) begin
      if (left_i.ins) begin
        valid_d = left_i.valid;
        rec_d   = left_i.rec;
      end else begin
        valid_d = 1'b1;
        rec_d   = new_rec_i;
      end
    end else if (pop_i) begin
      valid_d = right_i.valid;
      rec_d   = right_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.ins   = ins;
  assign link_o.rec   = rec_q;

endmodule

/* sv/fpq_out_buf.sv */
// two-beat result buffer between the queue and the master port
// depends on fpq_pkg and flow_priority_queue_defines.svh
`timescale 1ns / 1ps

`include "flow_priority_queue_defines.svh"

module fpq_out_buf import fpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  res_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output res_t rd_data_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       head_q, head_d;
  res_t       tail_q, tail_d;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = head_q;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // head is the oldest beat, tail the one behind it
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    case (cnt_q)
      2'd0: begin
        if (wr) head_d = wr_data_i;
      end
      2'd1: begin
        if (wr && rd) head_d = wr_data_i;
        else if (wr) tail_d = wr_data_i;
      end
      2'd2: begin
        if (rd) head_d = tail_q;
      end
      default: begin
        head_d = head_q;
      end
    endcase
    cnt_d = cnt_q + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  `FPQ_ASSERT(a_cnt_range, cnt_q != 2'd3, "result buffer count out of range")
  `FPQ_ASSERT_ALWAYS(a_cnt_reset, !rst_ni |-> cnt_q == 2'd0, "buffer not empty in reset")
  `FPQ_ASSERT(a_full_hold, (cnt_q == 2'd2 && !rd_ready_i) |=> cnt_q == 2'd2,
    "full buffer lost a beat while stalled")

endmodule

/* sv/flow_priority_queue.sv */
// flow priority queue: insert a flow record in sorted order, or pop the best one
// Slave channel: s_axis_tuser selects push (0) or pop (1); tdata carries the record.
// Master channel: one result beat per accepted item, in order. tuser is the status
// (done, pop on empty, push dropped because full); tdata carries the popped record
// (zero for pushes and failed pops) and the empty and full flags after the item.
// The records sit in a chain of DEPTH cells, best first. On a push every cell compares
// its record with the new one at once and the chain shifts right from the insert
// point; on a pop it shifts left. One item is taken each cycle while s_axis_tready is
// high, so the rate is one item per cycle, set by the single compare in each cell.
// A result is registered in the result buffer before it shows on the master port.
// A two-beat buffer holds results; while the receiver stalls, up to two results
// wait there, and s_axis_tready falls once both are held.
// Reset clears the cell valid bits and the result buffer: the queue comes up empty
// and ready at once, with no clearing pass.
// depends on fpq_pkg, fpq_cell, fpq_out_buf and flow_priority_queue_defines.svh
`timescale 1ns / 1ps

`include "flow_priority_queue_defines.svh"

module flow_priority_queue import fpq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // flow_id[7:0], arrival_time[23:8], transmit_time[39:24], priority_req[47:40]
  input  logic [47:0] s_axis_tdata,
  // mode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_flow_id[7:0], out_arrival_time[23:8], out_transmit_time[39:24],
  // out_priority[47:40], queue_empty[48], queue_full[49], zero pad[55:50]
  output logic [55:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  link_t            link [DEPTH];
  logic [DEPTH-1:0] valid_vec;
  rec_t             new_rec;
  logic             take, is_pop, full, empty, push_ok, pop_ok;
  res_t             res, out_res;

  assign new_rec = rec_t'(s_axis_tdata);
  assign take    = s_axis_tvalid && s_axis_tready;
  assign is_pop  = s_axis_tuser;
  assign full    = link[DEPTH-1].valid;
  assign empty   = !link[0].valid;
  assign push_ok = take && !is_pop && !full;
  assign pop_ok  = take && is_pop && !empty;

  // chain of cells, best record in cell 0
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    link_t left, right;
    if (k == 0) begin : g_first
      assign left = '{valid: 1'b0, ins: 1'b0, rec: new_rec};
    end else begin : g_mid_l
      assign left = link[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = '{valid: 1'b0, ins: 1'b0, rec: link[k].rec};
    end else begin : g_mid_r
      assign right = link[k+1];
    end
    fpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .push_i    (push_ok),
      .pop_i     (pop_ok),
      .new_rec_i (new_rec),
      .left_i    (left),
      .right_i   (right),
      .link_o    (link[k])
    );
    assign valid_vec[k] = link[k].valid;
  end

  // result of the item at the slave port
  always_comb begin
    res.rec    = '0;
    res.status = ST_DONE;
    res.empty  = empty;
    res.full   = full;
    if (is_pop) begin
      if (empty) begin
        res.status = ST_EMPTY;
      end else begin
        res.rec   = link[0].rec;
        res.empty = !link[1].valid;
        res.full  = 1'b0;
      end
    end else begin
      if (full) begin
        res.status = ST_DROP;
      end else begin
        res.empty = 1'b0;
        res.full  = link[DEPTH-2].valid;
      end
    end
  end

  fpq_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid),
    .wr_ready_o (s_axis_tready),
    .wr_data_i  (res),
    .rd_valid_o (m_axis_tvalid),
    .rd_ready_i (m_axis_tready),
    .rd_data_o  (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.full, out_res.empty, out_res.rec};
  assign m_axis_tuser = out_res.status;

  `FPQ_ASSERT(a_valid_packed, $onehot({1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1}),
    "valid cells are not a packed run from cell 0")
  `FPQ_ASSERT(a_push_grows, push_ok |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1,
    "accepted push did not add one record")
  `FPQ_ASSERT(a_head_sorted, link[1].valid |-> !ranks_before(link[1].rec, link[0].rec),
    "second record ranks before the head")

endmodule
